// ===== design/source_byte_tokenizer_macros.svh =====
// ----------------------------------------------------------------------------
// Source byte tokenizer assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SOURCE_BYTE_TOKENIZER_MACROS_SVH
`define SOURCE_BYTE_TOKENIZER_MACROS_SVH

`ifndef SYNTH

// Check that a condition holds at every edge
`define SBT_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle
`define SBT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define SBT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SBT_ASSERT(label, expr, msg)
`define SBT_ASSERT_IMP(label, ante, cons, msg)
`define SBT_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== design/sbt_pkg.sv =====
// ----------------------------------------------------------------------------
// Source byte tokenizer package
// Widths, lexer modes, token kinds, character codes and result bundle types.
// ----------------------------------------------------------------------------
package sbt_pkg;

    // Field widths
    localparam int POS_W  = 20;
    localparam int LEN_W  = 21;
    localparam int KIND_W = 4;
    localparam int MODE_W = 4;
    localparam int POS_LIM = 1 << POS_W;

    // Parameter defaults
    localparam int MAX_SOURCE_BYTES_DEF = 1048576;
    localparam int QUEUE_DEPTH_DEF      = 4;

    // Lexer modes (token kinds 0 to 4 share these codes)
    localparam logic [MODE_W-1:0] M_COMMENT = 4'd0;
    localparam logic [MODE_W-1:0] M_IDENT   = 4'd1;
    localparam logic [MODE_W-1:0] M_NUMBER  = 4'd2;
    localparam logic [MODE_W-1:0] M_DQUOTE  = 4'd3;
    localparam logic [MODE_W-1:0] M_SQUOTE  = 4'd4;
    localparam logic [MODE_W-1:0] M_NONE    = 4'd15;

    // Separator token kinds
    localparam logic [KIND_W-1:0] K_LPAREN  = 4'd5;
    localparam logic [KIND_W-1:0] K_RPAREN  = 4'd6;
    localparam logic [KIND_W-1:0] K_LBRACE  = 4'd7;
    localparam logic [KIND_W-1:0] K_RBRACE  = 4'd8;
    localparam logic [KIND_W-1:0] K_LBRACK  = 4'd9;
    localparam logic [KIND_W-1:0] K_RBRACK  = 4'd10;
    localparam logic [KIND_W-1:0] K_COMMA   = 4'd11;

    // Character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  line_number;
        logic [POS_W-1:0]  line_start;
        logic [POS_W-1:0]  token_start;
        logic [LEN_W-1:0]  length;
        logic              err;
    } res_t;

    // Results caused by one input byte: one, or two when two is set
    typedef struct packed {
        res_t r0;
        res_t r1;
        logic two;
    } bnd_t;

    // Operator class: ! # $ % & * + - . / : ; < = > ? @ \ ^ | ~
    function automatic logic is_op(input logic [7:0] c);
        return c inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B, 8'h2D,
                         8'h2E, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F,
                         8'h40, 8'h5C, 8'h5E, 8'h7C, 8'h7E};
    endfunction

    // Separators: [ ] { } ( ) , :
    function automatic logic is_sep(input logic [7:0] c);
        return c inside {8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h28, 8'h29, 8'h2C, 8'h3A};
    endfunction

endpackage

// ===== design/sbt_front.sv =====
// ----------------------------------------------------------------------------
// Source byte tokenizer front end
// Takes one byte a cycle unless the result queue is full, tracks lexer mode
// and positions, builds the bundle of results the byte causes and queues it.
// ----------------------------------------------------------------------------
`include "source_byte_tokenizer_macros.svh"

module sbt_front #(
    parameter int MAX_SOURCE_BYTES = sbt_pkg::MAX_SOURCE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          source_byte,
    input  logic                end_of_source,
    input  logic                keep_comments,
    input  logic                q_full,
    output logic                q_push,
    output sbt_pkg::bnd_t       q_data
);

    localparam int CNT_LIM = (MAX_SOURCE_BYTES < sbt_pkg::POS_LIM) ?
                             MAX_SOURCE_BYTES : sbt_pkg::POS_LIM;
    localparam int POS_MAX = CNT_LIM - 1;
    localparam int OFS_W   = $clog2(CNT_LIM + 1);
    localparam int LW      = sbt_pkg::LEN_W;
    localparam int PW      = sbt_pkg::POS_W;
    localparam logic [LW-1:0] CNT_LIM_V = LW'(CNT_LIM);
    localparam logic [LW-1:0] POS_MAX_V = LW'(POS_MAX);

    // Stream state
    logic [sbt_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [PW-1:0]              tb_reg, tb_next;
    logic [OFS_W-1:0]           ofs_reg, ofs_next;
    logic [PW-1:0]              line_reg, line_next;
    logic [PW-1:0]              lbeg_reg, lbeg_next;
    logic                       held_valid_reg, held_valid_next;
    logic                       held_slash_reg, held_slash_next;
    logic                       prev_op_reg, prev_op_next;
    logic                       halted_reg, halted_next;

    // Byte decode and step results
    logic                       accept;
    logic [LW-1:0]              idx;
    logic [PW-1:0]              pos, hpos;
    logic                       is_nl, is_blank, is_quote, cur_op, sep_c, is_digit;
    logic [sbt_pkg::MODE_W-1:0] m1, m2;
    logic [PW-1:0]              tb1, tb2;
    logic                       err, idle, close_hit, close_emit;
    logic [PW-1:0]              close_last;
    logic                       sep_hit, flush_emit, hold_set;
    logic [sbt_pkg::KIND_W-1:0] sep_kind;
    sbt_pkg::res_t              res_close, res_sep, res_flush, res_err;

    // Clamp a count to the last valid offset
    function automatic logic [PW-1:0] sat_pos(input logic [LW-1:0] k);
        logic [LW-1:0] s;
        s = (k < POS_MAX_V) ? k : POS_MAX_V;
        return s[PW-1:0];
    endfunction

    // Token length, at least one byte
    function automatic logic [LW-1:0] tok_len(input logic [PW-1:0] last,
                                              input logic [PW-1:0] start);
        logic [LW-1:0] d;
        d = {1'b0, last} - {1'b0, start} + LW'(1);
        return (last < start) ? LW'(1) : d;
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // Decode the byte
    assign idx      = LW'(ofs_reg);
    assign pos      = sat_pos(idx);
    assign hpos     = sat_pos((idx == '0) ? '0 : idx - LW'(1));
    assign is_nl    = (source_byte == sbt_pkg::CH_NL);
    assign is_blank = (source_byte == sbt_pkg::CH_SPACE) || (source_byte == sbt_pkg::CH_TAB);
    assign is_quote = (source_byte == sbt_pkg::CH_DQUOTE) ||
                      (source_byte == sbt_pkg::CH_SQUOTE);
    assign cur_op   = sbt_pkg::is_op(source_byte);
    assign sep_c    = sbt_pkg::is_sep(source_byte);
    assign is_digit = (source_byte >= sbt_pkg::CH_ZERO) && (source_byte <= sbt_pkg::CH_NINE);

    // Resolve a held byte into a comment or an identifier
    always_comb
    begin
        tb1 = tb_reg;
        m1  = mode_reg;
        if (held_valid_reg)
        begin
            tb1 = hpos;
            if (held_slash_reg)
                m1 = (source_byte == sbt_pkg::CH_SLASH) ? sbt_pkg::M_COMMENT : sbt_pkg::M_IDENT;
            else
                m1 = (source_byte == sbt_pkg::CH_BANG && !end_of_source) ?
                     sbt_pkg::M_COMMENT : sbt_pkg::M_IDENT;
        end
    end

    // Close the running token and reopen from idle
    always_comb
    begin
        err        = 1'b0;
        idle       = 1'b0;
        close_hit  = 1'b0;
        close_last = (pos > tb1) ? pos - PW'(1) : tb1;
        m2         = m1;
        tb2        = tb1;
        sep_hit    = 1'b0;
        sep_kind   = sbt_pkg::K_COMMA;
        hold_set   = 1'b0;
        if (is_nl)
        begin
            if (m1 == sbt_pkg::M_DQUOTE || m1 == sbt_pkg::M_SQUOTE)
                err = 1'b1;
            else
                close_hit = (m1 != sbt_pkg::M_NONE);
            m2 = sbt_pkg::M_NONE;
        end
        else
        begin
            case (m1)
                sbt_pkg::M_IDENT, sbt_pkg::M_NUMBER:
                begin
                    if (is_blank || is_quote || sep_c || (cur_op != prev_op_reg))
                    begin
                        close_hit = 1'b1;
                        idle      = 1'b1;
                    end
                end
                sbt_pkg::M_DQUOTE:
                begin
                    close_hit  = (source_byte == sbt_pkg::CH_DQUOTE);
                    close_last = pos;
                end
                sbt_pkg::M_SQUOTE:
                begin
                    close_hit  = (source_byte == sbt_pkg::CH_SQUOTE);
                    close_last = pos;
                end
                sbt_pkg::M_COMMENT:
                begin
                    idle = 1'b0;
                end
                default:
                begin
                    idle = 1'b1;
                end
            endcase
            if (close_hit || idle)
                m2 = sbt_pkg::M_NONE;
            if (idle)
            begin
                case (source_byte)
                    sbt_pkg::CH_DQUOTE:
                    begin
                        m2  = sbt_pkg::M_DQUOTE;
                        tb2 = pos;
                    end
                    sbt_pkg::CH_SQUOTE:
                    begin
                        m2  = sbt_pkg::M_SQUOTE;
                        tb2 = pos;
                    end
                    sbt_pkg::CH_LPAREN: begin sep_hit = 1'b1; sep_kind = sbt_pkg::K_LPAREN; end
                    sbt_pkg::CH_RPAREN: begin sep_hit = 1'b1; sep_kind = sbt_pkg::K_RPAREN; end
                    sbt_pkg::CH_LBRACE: begin sep_hit = 1'b1; sep_kind = sbt_pkg::K_LBRACE; end
                    sbt_pkg::CH_RBRACE: begin sep_hit = 1'b1; sep_kind = sbt_pkg::K_RBRACE; end
                    sbt_pkg::CH_LBRACK: begin sep_hit = 1'b1; sep_kind = sbt_pkg::K_LBRACK; end
                    sbt_pkg::CH_RBRACK: begin sep_hit = 1'b1; sep_kind = sbt_pkg::K_RBRACK; end
                    sbt_pkg::CH_COMMA:  begin sep_hit = 1'b1; sep_kind = sbt_pkg::K_COMMA;  end
                    default:
                    begin
                        if (!end_of_source && (source_byte == sbt_pkg::CH_SLASH ||
                            (source_byte == sbt_pkg::CH_HASH && idx == '0)))
                            hold_set = 1'b1;
                        else if (!is_blank)
                        begin
                            tb2 = pos;
                            m2  = is_digit ? sbt_pkg::M_NUMBER : sbt_pkg::M_IDENT;
                        end
                    end
                endcase
            end
        end
    end

    // Decide which results are reported
    assign close_emit = close_hit && (m1 != sbt_pkg::M_COMMENT || keep_comments);
    assign flush_emit = end_of_source && !err && (m2 != sbt_pkg::M_NONE) &&
                        (m2 != sbt_pkg::M_COMMENT || keep_comments);

    assign res_close = '{kind: m1, line_number: line_reg, line_start: lbeg_reg,
                         token_start: tb1, length: tok_len(close_last, tb1), err: 1'b0};
    assign res_sep   = '{kind: sep_kind, line_number: line_reg, line_start: lbeg_reg,
                         token_start: pos, length: LW'(1), err: 1'b0};
    assign res_flush = '{kind: m2, line_number: line_reg, line_start: lbeg_reg,
                         token_start: tb2, length: tok_len(pos, tb2), err: 1'b0};
    assign res_err   = '{kind: sbt_pkg::M_COMMENT, line_number: '0, line_start: '0,
                         token_start: '0, length: '0, err: 1'b1};

    // Pack results in order: close, separator, flush
    always_comb
    begin
        q_data.two = 1'b0;
        q_data.r0  = res_flush;
        q_data.r1  = res_flush;
        if (err)
            q_data.r0 = res_err;
        else if (close_emit)
        begin
            q_data.r0  = res_close;
            q_data.r1  = sep_hit ? res_sep : res_flush;
            q_data.two = sep_hit || flush_emit;
        end
        else if (sep_hit)
        begin
            q_data.r0  = res_sep;
            q_data.two = flush_emit;
        end
    end

    assign q_push = accept && !halted_reg && (err || close_emit || sep_hit || flush_emit);

    // Advance stream state
    always_comb
    begin
        mode_next       = mode_reg;
        tb_next         = tb_reg;
        ofs_next        = ofs_reg;
        line_next       = line_reg;
        lbeg_next       = lbeg_reg;
        held_valid_next = held_valid_reg;
        held_slash_next = held_slash_reg;
        prev_op_next    = prev_op_reg;
        halted_next     = halted_reg;
        if (accept && !halted_reg)
        begin
            if (err)
                halted_next = 1'b1;
            else if (end_of_source)
            begin
                mode_next       = sbt_pkg::M_NONE;
                tb_next         = '0;
                ofs_next        = '0;
                line_next       = '0;
                lbeg_next       = '0;
                held_valid_next = 1'b0;
                held_slash_next = 1'b0;
                prev_op_next    = 1'b0;
            end
            else
            begin
                mode_next       = m2;
                tb_next         = tb2;
                held_valid_next = hold_set;
                held_slash_next = (source_byte == sbt_pkg::CH_SLASH);
                prev_op_next    = cur_op;
                if (idx < CNT_LIM_V)
                    ofs_next = OFS_W'(idx + LW'(1));
                if (is_nl)
                begin
                    line_next = (line_reg == '1) ? line_reg : line_reg + PW'(1);
                    lbeg_next = sat_pos(idx + LW'(1));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= sbt_pkg::M_NONE;
            tb_reg         <= '0;
            ofs_reg        <= '0;
            line_reg       <= '0;
            lbeg_reg       <= '0;
            held_valid_reg <= 1'b0;
            held_slash_reg <= 1'b0;
            prev_op_reg    <= 1'b0;
            halted_reg     <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            tb_reg         <= tb_next;
            ofs_reg        <= ofs_next;
            line_reg       <= line_next;
            lbeg_reg       <= lbeg_next;
            held_valid_reg <= held_valid_next;
            held_slash_reg <= held_slash_next;
            prev_op_reg    <= prev_op_next;
            halted_reg     <= halted_next;
        end
    end

    // Checks
    `SBT_ASSERT_NXT(a_halt_sticks, halted_reg, halted_reg, "error halt released before reset")
    `SBT_ASSERT_IMP(a_held_idle, held_valid_reg, mode_reg == sbt_pkg::M_NONE,
                    "byte held while a token is open")

endmodule

// ===== design/sbt_queue.sv =====
// ----------------------------------------------------------------------------
// Source byte tokenizer result queue
// Short first-in first-out queue of result bundles between front and back.
// ----------------------------------------------------------------------------
`include "source_byte_tokenizer_macros.svh"

module sbt_queue #(
    parameter int DEPTH = sbt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sbt_pkg::bnd_t push_data,
    output logic          full,
    input  logic          pop,
    output sbt_pkg::bnd_t head,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sbt_pkg::bnd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the pushed bundle
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Checks
    `SBT_ASSERT(a_cnt_bound, cnt_reg <= CNT_FULL, "queue count beyond depth")
    `SBT_ASSERT_NXT(a_cnt_grow, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1,
                    "queue count did not grow on push")

endmodule

// ===== design/sbt_back.sv =====
// ----------------------------------------------------------------------------
// Source byte tokenizer back end
// Unpacks queued bundles into single results on the output channel, one per
// cycle while out_stall is low, and marks the last result of each input byte.
// ----------------------------------------------------------------------------
`include "source_byte_tokenizer_macros.svh"

module sbt_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  sbt_pkg::bnd_t               q_head,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sbt_pkg::KIND_W-1:0]  token_kind,
    output logic [sbt_pkg::POS_W-1:0]   line_number,
    output logic [sbt_pkg::POS_W-1:0]   line_start_pos,
    output logic [sbt_pkg::POS_W-1:0]   token_start_pos,
    output logic [sbt_pkg::LEN_W-1:0]   token_length,
    output logic                        literal_error,
    output logic                        last_in_run
);

    sbt_pkg::bnd_t bnd_reg;
    sbt_pkg::res_t cur;
    logic          bnd_valid_reg, bnd_valid_next;
    logic          sel_reg, sel_next;
    logic          take, done;

    assign take  = bnd_valid_reg && !out_stall;
    assign done  = !bnd_valid_reg || (take && (sel_reg || !bnd_reg.two));
    assign q_pop = done && !q_empty;

    // Step through the bundle, load the next one when done
    always_comb
    begin
        bnd_valid_next = bnd_valid_reg;
        sel_next       = sel_reg;
        if (q_pop)
        begin
            bnd_valid_next = 1'b1;
            sel_next       = 1'b0;
        end
        else if (take && !sel_reg && bnd_reg.two)
            sel_next = 1'b1;
        else if (take)
        begin
            bnd_valid_next = 1'b0;
            sel_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            bnd_valid_reg <= bnd_valid_next;
            sel_reg       <= sel_next;
        end
    end

    // Hold the bundle being delivered
    always_ff @(posedge clk)
    begin
        if (q_pop)
            bnd_reg <= q_head;
    end

    // Drive the current request
    assign cur             = sel_reg ? bnd_reg.r1 : bnd_reg.r0;
    assign out_valid       = bnd_valid_reg;
    assign token_kind      = cur.kind;
    assign line_number     = cur.line_number;
    assign line_start_pos  = cur.line_start;
    assign token_start_pos = cur.token_start;
    assign token_length    = cur.length;
    assign literal_error   = cur.err;
    assign last_in_run     = sel_reg || !bnd_reg.two;

    // Checks
    `SBT_ASSERT_IMP(a_sel_pair, sel_reg, bnd_valid_reg && bnd_reg.two,
                    "second result selected without a pair")

endmodule

// ===== design/source_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// Source byte tokenizer
// Cuts a byte stream into comment, identifier, number, literal, bracket and
// comma tokens with line and position information.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  input     in         in_valid / in_stall   source_byte, end_of_source
//  output    out        out_valid / out_stall token_kind, line_number,
//                                             line_start_pos, token_start_pos,
//                                             token_length, literal_error,
//                                             last_in_run
//  config    in         cfg_write             cfg_data (keep_comments)
//
//  One byte is taken per cycle while in_stall is low; a request passes the
//  result queue and the back end's bundle register on its way out, one
//  request per cycle while out_stall is low. A byte that causes two requests
//  sends them in turn; the result queue (QUEUE_DEPTH bundles) takes up the difference.
//  in_stall is high only while the result queue is full.
//  Reset clears all stream state and keep_comments; no clearing pass.
//  After a literal error, bytes are taken and dropped until reset.
//
`include "source_byte_tokenizer_macros.svh"

module source_byte_tokenizer #(
    parameter int MAX_SOURCE_BYTES = sbt_pkg::MAX_SOURCE_BYTES_DEF,
    parameter int QUEUE_DEPTH      = sbt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic                        cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  source_byte,
    input  logic                        end_of_source,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [sbt_pkg::KIND_W-1:0]  token_kind,
    output logic [sbt_pkg::POS_W-1:0]   line_number,
    output logic [sbt_pkg::POS_W-1:0]   line_start_pos,
    output logic [sbt_pkg::POS_W-1:0]   token_start_pos,
    output logic [sbt_pkg::LEN_W-1:0]   token_length,
    output logic                        literal_error,
    output logic                        last_in_run
);

    logic          keep_comments_reg;
    logic          q_push, q_full, q_pop, q_empty;
    sbt_pkg::bnd_t q_data, q_head;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            keep_comments_reg <= 1'b0;
        else if (cfg_write)
            keep_comments_reg <= cfg_data;
    end

    sbt_front #(
        .MAX_SOURCE_BYTES (MAX_SOURCE_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .source_byte   (source_byte),
        .end_of_source (end_of_source),
        .keep_comments (keep_comments_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_data)
    );

    sbt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    sbt_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .token_kind      (token_kind),
        .line_number     (line_number),
        .line_start_pos  (line_start_pos),
        .token_start_pos (token_start_pos),
        .token_length    (token_length),
        .literal_error   (literal_error),
        .last_in_run     (last_in_run)
    );

    // Checks
    `SBT_ASSERT_IMP(a_err_fields, out_valid && literal_error,
                    token_length == '0 && line_number == '0 && last_in_run,
                    "error request carries token fields")

endmodule

// ===== tb/sv/source_byte_tokenizer_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Source byte tokenizer testbench
// Feeds byte streams through the input channel with random gaps and random
// output back-pressure, predicts every token with a local lexer model, and
// compares each result field by field. Covers directed corner cases, random
// well-formed sources and the literal error.
// ----------------------------------------------------------------------------
module source_byte_tokenizer_test;

    import sbt_pkg::*;

    localparam int unsigned COUNT_LIMIT =
        (MAX_SOURCE_BYTES_DEF < POS_LIM) ? MAX_SOURCE_BYTES_DEF : POS_LIM;
    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(COUNT_LIMIT - 1);
    localparam logic [POS_W-1:0] LINE_LIMIT = '1;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic [7:0] value;
        logic       eos;
        logic [3:0] gap;
        logic       drain;
    } source_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  line_number;
        logic [POS_W-1:0]  line_start;
        logic [POS_W-1:0]  token_start;
        logic [LEN_W-1:0]  length;
        logic              err;
        logic              last;
    } token_t;

    // DUT ports
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic               cfg_data = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         source_byte = 8'h00;
    logic               end_of_source = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [KIND_W-1:0]  token_kind;
    logic [POS_W-1:0]   line_number;
    logic [POS_W-1:0]   line_start_pos;
    logic [POS_W-1:0]   token_start_pos;
    logic [LEN_W-1:0]   token_length;
    logic               literal_error;
    logic               last_in_run;

    // Stimulus and expected tokens
    source_item_t source_queue[$];
    source_item_t head_item;
    token_t       pending_tokens[$];
    token_t       step_tokens[$];
    int           wait_cycles = 0;
    int           hold_cycles = 0;
    int           stall_max = 0;
    int           quiet_cycles = 0;
    int           fail_count = 0;
    int           bytes_taken = 0;
    int           tokens_seen = 0;
    int           sources_sent = 0;

    // Lexer model state
    logic               keep_comments;
    logic [MODE_W-1:0]  lex_mode;
    logic [POS_W-1:0]   lex_begin;
    logic [LEN_W-1:0]   lex_offset;
    logic [POS_W-1:0]   lex_line;
    logic [POS_W-1:0]   lex_line_begin;
    logic [7:0]         lex_held;
    logic               lex_held_ok;
    logic               lex_prev_op;
    logic               lex_halted;

    source_byte_tokenizer DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .source_byte     (source_byte),
        .end_of_source   (end_of_source),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .token_kind      (token_kind),
        .line_number     (line_number),
        .line_start_pos  (line_start_pos),
        .token_start_pos (token_start_pos),
        .token_length    (token_length),
        .literal_error   (literal_error),
        .last_in_run     (last_in_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------

    function automatic logic op_class(input logic [7:0] c);
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h2F,
            8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h5C, 8'h5E, 8'h7C,
            8'h7E: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic separator_byte(input logic [7:0] c);
        case (c)
            CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN,
            CH_COMMA, 8'h3A: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] clip_pos(input logic [LEN_W-1:0] k);
        return (k < LAST_POS) ? k[POS_W-1:0] : LAST_POS;
    endfunction

    task automatic clear_stream();
        lex_mode       = M_NONE;
        lex_begin      = '0;
        lex_offset     = '0;
        lex_line       = '0;
        lex_line_begin = '0;
        lex_held       = '0;
        lex_held_ok    = 1'b0;
        lex_prev_op    = 1'b0;
    endtask

    task automatic emit_token(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] start,
                              input logic [LEN_W-1:0] len, input logic err);
        token_t t;
        t.kind        = kind;
        t.line_number = err ? '0 : lex_line;
        t.line_start  = err ? '0 : lex_line_begin;
        t.token_start = start;
        t.length      = len;
        t.err         = err;
        t.last        = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic close_token_at(input logic [POS_W-1:0] last_pos);
        logic [POS_W-1:0] stop;
        stop = (last_pos < lex_begin) ? lex_begin : last_pos;
        // drop comments unless they are kept
        if (lex_mode != M_COMMENT || keep_comments)
            emit_token(lex_mode, lex_begin, {1'b0, stop} - {1'b0, lex_begin} + 1'b1, 1'b0);
        lex_mode = M_NONE;
    endtask

    task automatic close_token_before(input logic [POS_W-1:0] pos);
        close_token_at((pos > lex_begin) ? pos - 1'b1 : lex_begin);
    endtask

    task automatic open_from_idle(input logic [7:0] c, input logic [LEN_W-1:0] idx,
                                  input logic [POS_W-1:0] pos, input logic more);
        logic [KIND_W-1:0] sep_kind;
        sep_kind = M_NONE;
        case (c)
            CH_DQUOTE: begin lex_mode = M_DQUOTE; lex_begin = pos; return; end
            CH_SQUOTE: begin lex_mode = M_SQUOTE; lex_begin = pos; return; end
            CH_LPAREN: sep_kind = K_LPAREN;
            CH_RPAREN: sep_kind = K_RPAREN;
            CH_LBRACE: sep_kind = K_LBRACE;
            CH_RBRACE: sep_kind = K_RBRACE;
            CH_LBRACK: sep_kind = K_LBRACK;
            CH_RBRACK: sep_kind = K_RBRACK;
            CH_COMMA:  sep_kind = K_COMMA;
            default: ;
        endcase
        if (sep_kind != M_NONE)
        begin
            emit_token(sep_kind, pos, LEN_W'(1), 1'b0);
            return;
        end
        // hold a slash, or a hash at the very start, until the next byte
        if (more && (c == CH_SLASH || (c == CH_HASH && idx == 0)))
        begin
            lex_held    = c;
            lex_held_ok = 1'b1;
            return;
        end
        if (c == CH_SPACE || c == CH_TAB)
            return;
        lex_begin = pos;
        lex_mode  = (c >= CH_ZERO && c <= CH_NINE) ? M_NUMBER : M_IDENT;
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic [LEN_W-1:0] idx, input logic more);
        logic [POS_W-1:0] pos;
        logic             cur_op;
        logic             to_idle;
        pos     = clip_pos(idx);
        cur_op  = op_class(c);
        to_idle = 1'b0;
        if (c == CH_NL)
        begin
            // line break inside a literal halts the stream
            if (lex_mode == M_DQUOTE || lex_mode == M_SQUOTE)
            begin
                emit_token('0, '0, '0, 1'b1);
                lex_halted = 1'b1;
                return;
            end
            if (lex_mode != M_NONE)
                close_token_before(pos);
            lex_line       = (lex_line < LINE_LIMIT) ? lex_line + 1'b1 : LINE_LIMIT;
            lex_line_begin = clip_pos((idx < COUNT_LIMIT) ? idx + 1'b1 : LEN_W'(COUNT_LIMIT));
        end
        else
        begin
            case (lex_mode)
                M_IDENT, M_NUMBER:
                    if (c == CH_SPACE || c == CH_TAB || c == CH_DQUOTE || c == CH_SQUOTE
                        || separator_byte(c) || cur_op != lex_prev_op)
                    begin
                        close_token_before(pos);
                        to_idle = 1'b1;
                    end
                M_DQUOTE:
                    if (c == CH_DQUOTE)
                        close_token_at(pos);
                M_SQUOTE:
                    if (c == CH_SQUOTE)
                        close_token_at(pos);
                M_COMMENT: ;
                default:
                begin
                    lex_mode = M_NONE;
                    to_idle  = 1'b1;
                end
            endcase
            if (to_idle)
                open_from_idle(c, idx, pos, more);
        end
        lex_prev_op = cur_op;
    endtask

    // Predict the tokens caused by one accepted byte
    task automatic tokenize_byte(input logic [7:0] c, input logic last);
        logic [LEN_W-1:0] idx;
        token_t           t;
        idx = lex_offset;
        bytes_taken++;
        if (lex_halted)
            return;
        step_tokens.delete();
        // resolve a held slash or hash
        if (lex_held_ok)
        begin
            lex_begin = clip_pos((idx > 0) ? idx - 1'b1 : idx);
            if (lex_held == CH_SLASH)
                lex_mode = (c == CH_SLASH) ? M_COMMENT : M_IDENT;
            else
                lex_mode = (c == CH_BANG && !last) ? M_COMMENT : M_IDENT;
            lex_held_ok = 1'b0;
            lex_held    = '0;
        end
        scan_byte(c, idx, !last);
        if (lex_offset < COUNT_LIMIT)
            lex_offset = lex_offset + 1'b1;
        // flush at end of source
        if (!lex_halted && last)
        begin
            if (lex_mode != M_NONE)
                close_token_at(clip_pos(idx));
            clear_stream();
        end
        if (step_tokens.size() > 0)
        begin
            t = step_tokens.pop_back();
            t.last = 1'b1;
            step_tokens.push_back(t);
        end
        foreach (step_tokens[i])
            pending_tokens.push_back(step_tokens[i]);
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued bytes after their gap
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid      <= 1'b0;
            source_byte   <= 8'h00;
            end_of_source <= 1'b0;
            wait_cycles   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                tokenize_byte(source_byte, end_of_source);
            if (!in_valid || !in_stall)
            begin
                if (source_queue.size() == 0
                    || (source_queue[0].drain && pending_tokens.size() != 0))
                begin
                    in_valid <= 1'b0;
                end
                else if (wait_cycles < source_queue[0].gap)
                begin
                    in_valid    <= 1'b0;
                    wait_cycles <= wait_cycles + 1;
                end
                else
                begin
                    head_item      = source_queue.pop_front();
                    in_valid      <= 1'b1;
                    source_byte   <= head_item.value;
                    end_of_source <= head_item.eos;
                    wait_cycles   <= 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted request, then draw the next stall
    // ------------------------------------------------------------------
    function automatic void match_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_token();
        token_t want;
        tokens_seen++;
        if (pending_tokens.size() == 0)
        begin
            $error("unexpected token: kind %0d start %0d", token_kind, token_start_pos);
            fail_count++;
        end
        else
        begin
            want = pending_tokens.pop_front();
            match_field("token_kind", 32'(want.kind), 32'(token_kind));
            match_field("line_number", 32'(want.line_number), 32'(line_number));
            match_field("line_start_pos", 32'(want.line_start), 32'(line_start_pos));
            match_field("token_start_pos", 32'(want.token_start), 32'(token_start_pos));
            match_field("token_length", 32'(want.length), 32'(token_length));
            match_field("literal_error", 32'(want.err), 32'(literal_error));
            match_field("last_in_run", 32'(want.last), 32'(last_in_run));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycles = 0;
            out_stall  <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_token();
                hold_cycles = $urandom_range(0, stall_max);
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles = hold_cycles - 1;
            end
            out_stall <= (hold_cycles > 0);
        end
    end

    // Watchdog on cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no request moved for %0d cycles", quiet_cycles);
                $display("*** FAILED ***");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic put_item(input logic [7:0] value, input logic eos, input int gap_max,
                            input logic drain);
        source_item_t item;
        item.value = value;
        item.eos   = eos;
        item.gap   = 4'($urandom_range(0, gap_max));
        item.drain = drain;
        source_queue.push_back(item);
    endtask

    task automatic queue_text(input string s, input logic eos_at_end, input int gap_max);
        for (int i = 0; i < s.len(); i++)
            put_item(s[i], eos_at_end && i == s.len() - 1, gap_max, 1'b0);
    endtask

    function automatic logic [7:0] pick_char(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Any byte except a line break and the quote(s), each where excluded
    function automatic logic [7:0] plain_byte(input logic no_nl, input logic no_dq,
                                              input logic no_sq);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((no_nl && c == CH_NL) || (no_dq && c == CH_DQUOTE) || (no_sq && c == CH_SQUOTE));
        return c;
    endfunction

    // Build one source of token-shaped fragments; a literal may stay open only at the end
    task automatic gen_source(input int target, input int gap_max, input logic drain_first);
        logic [7:0] src[$];
        logic [7:0] q;
        int         pick;
        if ($urandom_range(0, 5) == 0)
        begin
            src.push_back(CH_HASH);
            if ($urandom_range(0, 1))
                src.push_back(CH_BANG);
        end
        while (src.size() < target)
        begin
            pick = $urandom_range(0, 13);
            case (pick)
                0, 1, 13:
                begin
                    src.push_back(pick_char("abcxyzABQZ_"));
                    repeat ($urandom_range(0, 5))
                        src.push_back(pick_char("abmz_AZ09"));
                end
                2:
                begin
                    src.push_back(pick_char("0123456789"));
                    repeat ($urandom_range(0, 4))
                        src.push_back(pick_char("0179xe_"));
                end
                3:
                    repeat ($urandom_range(1, 3))
                        src.push_back(pick_char("!#$&*+-;:./<=>?@\\^~|%"));
                4, 12:
                    src.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                5:
                    src.push_back(CH_NL);
                6, 7:
                begin
                    q = (pick == 6) ? CH_DQUOTE : CH_SQUOTE;
                    src.push_back(q);
                    repeat ($urandom_range(0, 4))
                        src.push_back(plain_byte(1'b1, q == CH_DQUOTE, q == CH_SQUOTE));
                    src.push_back(q);
                end
                8:
                    src.push_back(pick_char("[]{}(),"));
                9:
                begin
                    src.push_back(CH_SLASH);
                    src.push_back(CH_SLASH);
                    repeat ($urandom_range(0, 6))
                        src.push_back(plain_byte(1'b1, 1'b1, 1'b1));
                    src.push_back(CH_NL);
                end
                10:
                    src.push_back(plain_byte(1'b0, 1'b1, 1'b1));
                default:
                    src.push_back($urandom_range(0, 1) ? CH_SLASH : CH_HASH);
            endcase
        end
        // sometimes leave a literal open so the end of source flushes it
        if ($urandom_range(0, 7) == 0)
        begin
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            src.push_back(q);
            repeat ($urandom_range(0, 3))
                src.push_back(plain_byte(1'b1, 1'b1, 1'b1));
        end
        foreach (src[i])
            put_item(src[i], i == src.size() - 1, gap_max, drain_first && i == 0);
        sources_sent++;
    endtask

    task automatic set_keep(input logic value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        keep_comments = value;
    endtask

    // Wait until every byte is taken and every token has come back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (source_queue.size() != 0 || in_valid || pending_tokens.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase_keep[6]  = '{0, 1, 1, 0, 1, 0};
        int phase_gap[6]   = '{8, 0, 8, 0, 8, 3};
        int phase_stall[6] = '{8, 0, 0, 8, 8, 2};
        int phase_bytes;
        int n_src;

        keep_comments = 1'b0;
        lex_halted    = 1'b0;
        clear_stream();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: leading #! comment, held slash, comment, every separator,
        // both literals, class change, tab, top byte, then #! as a whole source
        stall_max = 3;
        set_keep(1'b1);
        queue_text("#!x\n/a//c\n(){}[],\"s\"'q'9+a\t", 1'b0, 3);
        put_item(8'hFF, 1'b1, 3, 1'b0);
        queue_text("#!", 1'b1, 3);
        wait_idle();

        // Random phases with changing comment setting, gaps and stalls
        for (int p = 0; p < 6; p++)
        begin
            set_keep(phase_keep[p][0]);
            stall_max   = phase_stall[p];
            phase_bytes = source_queue.size();
            n_src       = 0;
            while (source_queue.size() - phase_bytes < 200)
            begin
                gen_source(($urandom_range(0, 4) == 0) ? $urandom_range(13, 60)
                                                       : $urandom_range(1, 12),
                           phase_gap[p], p == 4 && n_src == 3);
                n_src++;
            end
            wait_idle();
        end

        // Line break in a literal halts; everything after is dropped
        stall_max = 8;
        queue_text("q \"k\n", 1'b0, 4);
        queue_text("z)", 1'b1, 4);
        wait_idle();

        $display("Run: %0d bytes taken, %0d random sources, %0d tokens checked",
                 bytes_taken, sources_sent, tokens_seen);
        $display("Run: comments kept and dropped, held bytes, literal error halt");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/sbt_pkg.sv
design/sbt_front.sv
design/sbt_queue.sv
design/sbt_back.sv
design/source_byte_tokenizer.sv
tb/sv/source_byte_tokenizer_test.sv
